>>> rtl/core/rcpwm_pkg.sv
package rcpwm_pkg;

    // Fixed widths of the item fields
    localparam int TIME_W   = 16;
    localparam int LEVELS_W = 8;
    localparam int MAP_W    = 24;
    localparam int DB_W     = 4;
    localparam int CHAN_W   = 3;
    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W   = 3;
    localparam int HIST_DEPTH = 4;
    localparam int RING_W   = 2;

    // Reset values
    localparam logic [TIME_W-1:0] MIN_PULSE_RESET = 16'd900;
    localparam logic [TIME_W-1:0] MAX_PULSE_RESET = 16'd2200;
    localparam logic [MAP_W-1:0]  CHAN_MAP_RESET  = 24'hFAC688;
    localparam logic [DB_W-1:0]   DEADBAND_RESET  = 4'd3;
    localparam logic [TIME_W-1:0] RAW_RESET       = 16'd1502;

    // Output offset from a mean past the dead band; also rounds the mean
    localparam logic [TIME_W+1:0] FILT_STEP = 18'd2;

    typedef enum logic {
        OP_PIN     = 1'b0,
        OP_COMPUTE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_MIN_PULSE   = 2'd0,
        REG_MAX_PULSE   = 2'd1,
        REG_CHANNEL_MAP = 2'd2,
        REG_DEADBAND    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] min_pulse;
        logic [TIME_W-1:0] max_pulse;
        logic [MAP_W-1:0]  channel_map;
        logic [DB_W-1:0]   deadband;
    } cfg_t;

    // Snapshot of all raw slots handed from front to back
    typedef logic [NUM_SLOTS-1:0][TIME_W-1:0] raw_arr_t;

    // Fixed wiring of receiver line to raw slot
    function automatic logic [SLOT_W-1:0] line_slot(input logic [SLOT_W-1:0] line);
        logic [SLOT_W-1:0] slot;
        unique case (line)
            3'd0:    slot = 3'd2;
            3'd1:    slot = 3'd4;
            3'd2:    slot = 3'd5;
            3'd3:    slot = 3'd6;
            3'd4:    slot = 3'd7;
            3'd5:    slot = 3'd0;
            3'd6:    slot = 3'd1;
            default: slot = 3'd3;
        endcase
        return slot;
    endfunction

endpackage

>>> rtl/core/rcpwm_front.sv
module rcpwm_front #(
    parameter int NUM_LINES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rcpwm_pkg::cfg_t                     cfg,
    input  logic                                fire,
    input  logic                                opcode,
    input  logic [rcpwm_pkg::LEVELS_W-1:0]      pin_levels,
    input  logic [rcpwm_pkg::TIME_W-1:0]        time_us,
    output logic                                push,
    output rcpwm_pkg::raw_arr_t                 push_data
);
    import rcpwm_pkg::*;

    logic [LEVELS_W-1:0] prev_levels_reg;
    logic [NUM_LINES-1:0][TIME_W-1:0] rise_time_reg;
    raw_arr_t raw_width_reg;
    logic [LEVELS_W-1:0] changed;
    logic [NUM_LINES-1:0][TIME_W-1:0] width;
    logic [NUM_LINES-1:0] store;

    assign changed = pin_levels ^ prev_levels_reg;

    // Width per line and range check, all lines in parallel
    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            width[i] = time_us - rise_time_reg[i];
            store[i] = changed[i] && !pin_levels[i]
                       && (cfg.min_pulse < width[i]) && (width[i] < cfg.max_pulse);
        end
    end

    // A compute beat carries the raw slots as they stand
    assign push      = fire && (opcode == OP_COMPUTE);
    assign push_data = raw_width_reg;

    // Edge capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '0;
            rise_time_reg   <= '0;
            for (int s = 0; s < NUM_SLOTS; s++)
                raw_width_reg[s] <= RAW_RESET;
        end
        else if (fire && (opcode == OP_PIN))
        begin
            prev_levels_reg <= pin_levels;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                if (changed[i] && pin_levels[i])
                    rise_time_reg[i] <= time_us;
                if (store[i])
                    raw_width_reg[line_slot(SLOT_W'(i))] <= width[i];
            end
        end
    end

endmodule

>>> rtl/core/rcpwm_queue.sv
module rcpwm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rcpwm_pkg::raw_arr_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output rcpwm_pkg::raw_arr_t pop_data
);
    import rcpwm_pkg::*;

    raw_arr_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

>>> rtl/core/rcpwm_back.sv
module rcpwm_back #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rcpwm_pkg::cfg_t                  cfg,
    input  logic                             q_empty,
    input  rcpwm_pkg::raw_arr_t              q_data,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rcpwm_pkg::CHAN_W-1:0]     channel,
    output logic [rcpwm_pkg::TIME_W-1:0]     value,
    output logic                             last
);
    import rcpwm_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

    logic [HIST_DEPTH-1:0][TIME_W-1:0] hist_reg [NUM_CHANNELS];
    logic [TIME_W-1:0] filt_reg [NUM_CHANNELS];
    logic [RING_W-1:0] ring_reg;
    logic [CH_W-1:0]   ch1_reg;

    logic              s2_valid_reg;
    logic [CH_W-1:0]   s2_ch_reg;
    logic [TIME_W-1:0] s2_mean_reg;
    logic              s2_last_reg;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_ch_reg;
    logic [TIME_W-1:0] out_value_reg;
    logic              out_last_reg;

    logic stall;
    logic s1_fire;
    logic s1_last;
    logic [RING_W-1:0] cur_ring;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] raw;
    logic [HIST_DEPTH-1:0][TIME_W-1:0] row_next;
    logic [TIME_W+1:0] sum;
    logic [TIME_W-1:0] mean_next;
    logic [TIME_W+1:0] mean_x, f0, f1, f2, db_x, up, dn;

    assign stall   = out_valid_reg && !out_ready;
    assign s1_fire = !q_empty && !stall;
    assign s1_last = (ch1_reg == CH_LAST);
    assign q_pop   = s1_fire && s1_last;

    // Stage 1: new history entry and rounded mean of the row
    always_comb
    begin
        cur_ring = (ch1_reg == '0) ? ring_reg + RING_W'(1) : ring_reg;
        slot     = cfg.channel_map[SLOT_W*ch1_reg +: SLOT_W];
        raw      = q_data[slot];
        row_next = hist_reg[ch1_reg];
        row_next[cur_ring] = raw;
        sum = {2'b00, row_next[0]} + {2'b00, row_next[1]}
            + {2'b00, row_next[2]} + {2'b00, row_next[3]};
        mean_next = TIME_W'((sum + FILT_STEP) >> 2);
    end

    // Stage 2: dead band around the previous output
    always_comb
    begin
        mean_x = {2'b00, s2_mean_reg};
        db_x   = {{(TIME_W-2){1'b0}}, cfg.deadband};
        f0     = {2'b00, filt_reg[s2_ch_reg]};
        up     = mean_x + FILT_STEP;
        f1     = f0;
        if (mean_x + db_x < f0)
            f1 = (up > {2'b00, {TIME_W{1'b1}}}) ? {2'b00, {TIME_W{1'b1}}} : up;
        dn = (mean_x < FILT_STEP) ? '0 : mean_x - FILT_STEP;
        f2 = f1;
        if (mean_x > f1 + db_x)
            f2 = dn;
    end

    // Channel walk, history and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= '0;
            ch1_reg       <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                hist_reg[c] <= '0;
                filt_reg[c] <= '0;
            end
        end
        else
        begin
            if (s1_fire)
            begin
                hist_reg[ch1_reg] <= row_next;
                ring_reg <= cur_ring;
                ch1_reg  <= s1_last ? '0 : ch1_reg + CH_W'(1);
            end
            if (!stall)
                s2_valid_reg <= s1_fire;
            if (s2_valid_reg && !stall)
                filt_reg[s2_ch_reg] <= f2[TIME_W-1:0];
            if (s2_valid_reg && !stall)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage and output payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_ch_reg   <= ch1_reg;
            s2_mean_reg <= mean_next;
            s2_last_reg <= s1_last;
        end
        if (s2_valid_reg && !stall)
        begin
            out_ch_reg    <= CHAN_W'(s2_ch_reg);
            out_value_reg <= f2[TIME_W-1:0];
            out_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = out_ch_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

endmodule

>>> rtl/core/rc_pwm_capture_and_smoothing_top.sv
// Channel   Dir  Handshake                Payload
// in        in   in_valid / in_ready      opcode, pin_levels, time_us
// out       out  out_valid / out_ready    channel, value, last
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A pin-change beat is absorbed by the capture front end.
// A compute beat queues a raw-slot snapshot (two deep); the back end walks
// one channel per cycle through a two-stage mean/dead-band pipe, so a
// compute item yields NUM_CHANNELS results. A held result stalls the walk.
// Reset is asynchronous and active low; cfg is always ready.
module rc_pwm_capture_and_smoothing_top #(
    parameter int NUM_LINES    = 8,
    parameter int NUM_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [rcpwm_pkg::LEVELS_W-1:0]   pin_levels,
    input  logic [rcpwm_pkg::TIME_W-1:0]     time_us,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rcpwm_pkg::CHAN_W-1:0]     channel,
    output logic [rcpwm_pkg::TIME_W-1:0]     value,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [rcpwm_pkg::MAP_W-1:0]      cfg_data
);
    import rcpwm_pkg::*;

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    logic     push;
    logic     in_fire;
    raw_arr_t push_data;
    raw_arr_t q_data;

    // Pin beats never wait; compute beats need queue room
    assign in_ready  = (opcode == OP_PIN) || !q_full;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_pulse   <= MIN_PULSE_RESET;
            cfg_reg.max_pulse   <= MAX_PULSE_RESET;
            cfg_reg.channel_map <= CHAN_MAP_RESET;
            cfg_reg.deadband    <= DEADBAND_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_PULSE:   cfg_reg.min_pulse   <= cfg_data[TIME_W-1:0];
                REG_MAX_PULSE:   cfg_reg.max_pulse   <= cfg_data[TIME_W-1:0];
                REG_CHANNEL_MAP: cfg_reg.channel_map <= cfg_data;
                REG_DEADBAND:    cfg_reg.deadband    <= cfg_data[DB_W-1:0];
                default:         cfg_reg.deadband    <= cfg_reg.deadband;
            endcase
        end
    end

    rcpwm_front #(
        .NUM_LINES (NUM_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fire       (in_fire),
        .opcode     (opcode),
        .pin_levels (pin_levels),
        .time_us    (time_us),
        .push       (push),
        .push_data  (push_data)
    );

    rcpwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    rcpwm_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .channel   (channel),
        .value     (value),
        .last      (last)
    );

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpwm_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_CH        = 8;
    localparam int PHASE_ITEMS   = 21;

    // Receiver line to raw slot, 3 bits per line, line 0 in the low bits
    localparam logic [23:0] SLOT_OF_LINE = {3'd3, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd2};

    // Saturation walk: channel 1 reads slot 2 (3 us pulse), channel 0 is
    // switched between slots 7/4/5/6 holding 65534/65522/65526/65530 us
    localparam logic [20:0] WALK_UPPER = {3'd3, 3'd1, 3'd0, 3'd6, 3'd5, 3'd4, 3'd2};
    localparam logic [11:0] WALK_SLOTS = {3'd7, 3'd6, 3'd5, 3'd4};

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] value;
        logic              last;
    } chan_beat_t;

    // Pulse capture and smoothing predictor plus expected channel beats
    class pwm_scoreboard;
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
        logic [23:0] chan_map;
        logic [3:0]  deadband;
        logic [7:0]  prev_levels;
        logic [15:0] rise_at [8];
        logic [15:0] raw_width [8];
        logic [15:0] history [8][4];
        logic [1:0]  ring;
        logic [15:0] smoothed [8];
        chan_beat_t  expected_q [$];
        int          errors;

        function new();
            min_pulse   = MIN_PULSE_RESET;
            max_pulse   = MAX_PULSE_RESET;
            chan_map    = CHAN_MAP_RESET;
            deadband    = DEADBAND_RESET;
            prev_levels = '0;
            ring        = '0;
            errors      = 0;
            for (int i = 0; i < 8; i++)
            begin
                rise_at[i]   = '0;
                raw_width[i] = RAW_RESET;
                smoothed[i]  = '0;
                for (int k = 0; k < 4; k++)
                    history[i][k] = '0;
            end
        endfunction

        function void set_reg(reg_index_t idx, logic [23:0] d);
            case (idx)
                REG_MIN_PULSE:   min_pulse = d[15:0];
                REG_MAX_PULSE:   max_pulse = d[15:0];
                REG_CHANNEL_MAP: chan_map  = d;
                REG_DEADBAND:    deadband  = d[3:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction

        // Edge detect; a falling edge stores the wrapped width if in range
        function void capture_edges(logic [7:0] lv, logic [15:0] t);
            logic [7:0]  changed;
            logic [15:0] w;
            changed     = lv ^ prev_levels;
            prev_levels = lv;
            for (int i = 0; i < 8; i++)
            begin
                if (changed[i])
                begin
                    if (lv[i])
                        rise_at[i] = t;
                    else
                    begin
                        w = t - rise_at[i];
                        if (min_pulse < w && w < max_pulse)
                            raw_width[SLOT_OF_LINE[3*i +: 3]] = w;
                    end
                end
            end
        endfunction

        // Advance ring, rounded mean of 4, dead band with saturating step
        function void smooth_channels();
            logic [2:0]  slot;
            logic [17:0] sum;
            int          mean;
            int          f;
            ring = ring + 2'd1;
            for (int c = 0; c < NUM_CH; c++)
            begin
                slot = chan_map[3*c +: 3];
                history[c][ring] = raw_width[slot];
                sum = '0;
                for (int k = 0; k < 4; k++)
                    sum = sum + 18'(history[c][k]);
                mean = int'((sum + 18'd2) >> 2);
                f = int'(smoothed[c]);
                if (mean < f - int'(deadband))
                begin
                    f = mean + 2;
                    if (f > 65535)
                        f = 65535;
                end
                if (mean > f + int'(deadband))
                begin
                    f = mean - 2;
                    if (f < 0)
                        f = 0;
                end
                smoothed[c] = f[15:0];
                expected_q.push_back('{channel: 3'(c), value: smoothed[c],
                                       last: (c == NUM_CH - 1)});
            end
        endfunction

        function void note_input(opcode_t op, logic [7:0] lv, logic [15:0] t);
            if (op == OP_COMPUTE)
                smooth_channels();
            else
                capture_edges(lv, t);
        endfunction

        task check_beat(logic [2:0] ch, logic [15:0] v, logic l);
            chan_beat_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat channel %0d value %0d", ch, v));
                return;
            end
            want = expected_q.pop_front();
            if (ch !== want.channel)
                report($sformatf("channel got %0d, want %0d", ch, want.channel));
            if (v !== want.value)
                report($sformatf("channel %0d value got %0d, want %0d",
                                 want.channel, v, want.value));
            if (l !== want.last)
                report($sformatf("channel %0d last got %0b, want %0b",
                                 want.channel, l, want.last));
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                opcode     = 1'b0;
    logic [LEVELS_W-1:0] pin_levels = '0;
    logic [TIME_W-1:0]   time_us    = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [CHAN_W-1:0]   channel;
    logic [TIME_W-1:0]   value;
    logic                last;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index  = '0;
    logic [MAP_W-1:0]    cfg_data   = '0;

    pwm_scoreboard sb;
    int            burst_left = 0;
    int            cycle_count;
    int            stall_mode = 0;
    int            mode_left  = 0;
    logic [7:0]    levels_now = '0;
    logic [15:0]   now_us     = '0;
    logic [15:0]   cur_min    = MIN_PULSE_RESET;
    logic [15:0]   cur_max    = MAX_PULSE_RESET;

    rc_pwm_capture_and_smoothing_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .pin_levels (pin_levels),
        .time_us    (time_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel    (channel),
        .value      (value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side backpressure: modes of random length
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 80);
        end
        mode_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (mode_left % 3 == 0);
        endcase
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(channel, value, last);
    end

    // One input beat; bursts with random gaps. Entered and left at negedge.
    task automatic send_item(opcode_t op, logic [7:0] lv, logic [15:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_valid   <= 1'b1;
        opcode     <= op;
        pin_levels <= lv;
        time_us    <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(op, lv, t);
        @(negedge clk);
    endtask

    task automatic send_compute();
        send_item(OP_COMPUTE, 8'($urandom), 16'($urandom));
    endtask

    // Hold off input until every expected beat is back, then let the
    // capture front end settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [15:0] mn, logic [15:0] mx, logic [23:0] map,
                                logic [3:0] db);
        quiesce();
        write_reg(REG_MIN_PULSE, 24'(mn));
        write_reg(REG_MAX_PULSE, 24'(mx));
        write_reg(REG_CHANNEL_MAP, map);
        write_reg(REG_DEADBAND, 24'(db));
        cfg_valid <= 1'b0;
        cur_min = mn;
        cur_max = mx;
    endtask

    // Rise on the masked lines, fall after the given width, then a gap
    task automatic send_pulse(logic [7:0] mask, logic [15:0] width);
        levels_now = levels_now | mask;
        send_item(OP_PIN, levels_now, now_us);
        now_us     = now_us + width;
        levels_now = levels_now & ~mask;
        send_item(OP_PIN, levels_now, now_us);
        now_us     = now_us + 16'($urandom_range(20, 3000));
    endtask

    // Mostly in-range widths, with the exact limits and wild values mixed in
    function automatic logic [15:0] pick_width();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0:       return cur_min;
            1:       return cur_min + 16'd1;
            2:       return cur_max - 16'd1;
            3:       return cur_max;
            4:       return 16'($urandom);
            default:
                if (int'(cur_max) > int'(cur_min) + 2)
                    return 16'($urandom_range(int'(cur_min) + 1, int'(cur_max) - 1));
                else
                    return 16'($urandom_range(800, 2300));
        endcase
    endfunction

    initial
    begin
        int         items;
        int         r;
        bit         held;
        logic [7:0] mask;

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 3 us pulse on line 0 and wrapped long pulses on lines 1-4
        program_regs(16'd0, 16'hFFFF, {WALK_UPPER, 3'd7}, 4'd0);
        send_item(OP_PIN, 8'h1F, 16'd100);
        send_item(OP_PIN, 8'h1E, 16'd103);
        send_item(OP_PIN, 8'h1C, 16'd86);
        send_item(OP_PIN, 8'h18, 16'd90);
        send_item(OP_PIN, 8'h10, 16'd94);
        send_item(OP_PIN, 8'h00, 16'd98);

        // First compute drives channel 1 below zero (clamped); fill channel 0
        repeat (4) send_compute();

        // Walk channel 0 up to the top clamp: hold with a wide dead band while
        // the history shifts, then one narrow-band compute per step
        for (int s = 0; s < 4; s++)
        begin
            if (s > 0)
            begin
                program_regs(16'd0, 16'hFFFF, {WALK_UPPER, 3'd7}, 4'd15);
                repeat (3) send_compute();
            end
            program_regs(16'd0, 16'hFFFF, {WALK_UPPER, WALK_SLOTS[3*s +: 3]}, 4'd0);
            send_compute();
        end

        // Random phases, each with its own register setting
        now_us = 16'hF000;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: program_regs(MIN_PULSE_RESET, MAX_PULSE_RESET, CHAN_MAP_RESET,
                                DEADBAND_RESET);
                1: program_regs(16'd0, 16'hFFFF, 24'h000000, 4'hF);
                2: program_regs(16'hFFFF, 16'd0, 24'hFFFFFF, 4'h0);
                default: program_regs(16'($urandom_range(0, 1200)),
                                      16'($urandom_range(1600, 65535)),
                                      24'($urandom), 4'($urandom));
            endcase
            items = 0;
            held  = 1'b0;
            while (items < PHASE_ITEMS)
            begin
                if (!held && items >= 12)
                begin
                    quiesce();
                    held = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    send_pulse(8'd1 << $urandom_range(0, 7), pick_width());
                    items += 2;
                end
                else if (r < 65)
                begin
                    mask = 8'($urandom_range(1, 255));
                    send_pulse(mask, pick_width());
                    items += 2;
                end
                else if (r < 85)
                begin
                    send_compute();
                    items++;
                end
                else
                begin
                    // noise: arbitrary levels, sometimes a time jump
                    levels_now = 8'($urandom);
                    if ($urandom_range(0, 1) == 1)
                        now_us = 16'($urandom);
                    else
                        now_us = now_us + 16'($urandom_range(1, 40));
                    send_item(OP_PIN, levels_now, now_us);
                    items++;
                end
            end
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
